@@ hdl/clt_pkg.sv @@
`default_nettype none

package clt_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned ResMax     = 3;

  // result kinds
  localparam logic [2:0] KindParamByte = 3'd0;
  localparam logic [2:0] KindParamEnd  = 3'd1;
  localparam logic [2:0] KindCommand   = 3'd2;
  localparam logic [2:0] KindSender    = 3'd3;
  localparam logic [2:0] KindTarget    = 3'd4;
  localparam logic [2:0] KindLineOk    = 3'd5;
  localparam logic [2:0] KindLineErr   = 3'd6;

  // error codes
  localparam logic [3:0] ErrShort       = 4'd0;
  localparam logic [3:0] ErrBadType     = 4'd1;
  localparam logic [3:0] ErrEscAtEnd    = 4'd2;
  localparam logic [3:0] ErrUnknownEsc  = 4'd3;
  localparam logic [3:0] ErrIdLength    = 4'd4;
  localparam logic [3:0] ErrFeatLength  = 4'd5;
  localparam logic [3:0] ErrNoSender    = 4'd6;
  localparam logic [3:0] ErrNoFeature   = 4'd7;
  localparam logic [3:0] ErrNoTarget    = 4'd8;

  // register indexes
  localparam logic RegLegacyMode = 1'b0;
  localparam logic RegHubId      = 1'b1;

  localparam logic [7:0] ChS         = 8'h73;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChB         = 8'h42;
  localparam logic [7:0] ChC         = 8'h43;
  localparam logic [7:0] ChD         = 8'h44;
  localparam logic [7:0] ChE         = 8'h45;
  localparam logic [7:0] ChF         = 8'h46;
  localparam logic [7:0] ChH         = 8'h48;
  localparam logic [7:0] ChI         = 8'h49;
  localparam logic [7:0] ChU         = 8'h55;

  typedef enum logic [1:0] {
    RoleParam,
    RoleSender,
    RoleTarget,
    RoleFeature
  } role_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [31:0] word_value;
    logic [3:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                  count;
    out_item_t [ResMax-1:0]      items;
  } bundle_t;

  function automatic logic type_valid(logic [7:0] t);
    return t inside {ChB, ChC, ChD, ChE, ChF, ChH, ChI, ChU};
  endfunction

  function automatic logic needs_sender(logic [7:0] t);
    return t inside {ChB, ChD, ChE, ChF};
  endfunction

  function automatic logic needs_target(logic [7:0] t);
    return t inside {ChD, ChE};
  endfunction

  function automatic role_e token_role(logic [7:0] t, logic ss, logic ts, logic fs);
    role_e r;
    if (needs_sender(t) && !ss) r = RoleSender;
    else if (needs_target(t) && !ts) r = RoleTarget;
    else if (t == ChF && !fs) r = RoleFeature;
    else r = RoleParam;
    return r;
  endfunction

  function automatic out_item_t mk_item(logic [2:0] k, logic [7:0] b, logic [31:0] w,
                                        logic [3:0] e);
    out_item_t it;
    it.kind        = k;
    it.out_byte    = b;
    it.word_value  = w;
    it.error_code  = e;
    it.last_of_run = 1'b0;
    return it;
  endfunction

endpackage

`default_nettype wire

@@ hdl/clt_front.sv @@
`default_nettype none

module clt_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               legacy_mode_i,
  input  wire logic [31:0]        hub_id_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire clt_pkg::in_item_t  in_item_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output clt_pkg::bundle_t        q_data_o
);

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  lt_q, lt_d;
  logic [23:0] cmd_q, cmd_d;
  logic        esc_q, esc_d;
  logic        ss_q, ss_d;
  logic        ts_q, ts_d;
  logic        fs_q, fs_d;
  logic [2:0]  tl_q, tl_d;
  logic [2:0]  tm5_q, tm5_d;
  logic [31:0] idc_q, idc_d;
  logic        disc_q, disc_d;

  logic                                  accept;
  logic [1:0]                            nres;
  clt_pkg::out_item_t [clt_pkg::ResMax-1:0] items;

  assign accept     = in_valid_i & ~q_full_i;
  assign in_stall_o = q_full_i;

  always_comb begin
    logic [7:0]     c;
    logic           eol;
    logic [3:0]     hlen;
    logic [3:0]     first;
    logic [3:0]     sh;
    logic           fin;
    logic           app;
    logic [7:0]     app_byte;
    clt_pkg::role_e role;

    c        = in_item_i.in_byte;
    eol      = in_item_i.line_end;
    hlen     = legacy_mode_i ? 4'd7 : 4'd4;
    first    = legacy_mode_i ? 4'd4 : 4'd1;
    sh       = '0;
    fin      = 1'b0;
    app      = 1'b0;
    app_byte = c;
    role     = clt_pkg::RoleParam;

    pos_d  = pos_q;
    lt_d   = lt_q;
    cmd_d  = cmd_q;
    esc_d  = esc_q;
    ss_d   = ss_q;
    ts_d   = ts_q;
    fs_d   = fs_q;
    tl_d   = tl_q;
    tm5_d  = tm5_q;
    idc_d  = idc_q;
    disc_d = disc_q;
    nres   = '0;
    items  = '0;

    if (disc_d) begin
      // rest of line dropped
    end else if (pos_d < hlen) begin
      if (!legacy_mode_i && pos_d == 4'd0) lt_d = c;
      if (pos_d >= first && (pos_d - first) < 4'd3) begin
        sh = pos_d - first;
        cmd_d[8*sh[1:0] +: 8] = c;
      end
      if (pos_d == hlen - 4'd1) begin
        if (legacy_mode_i) lt_d = clt_pkg::ChC;
        if (!clt_pkg::type_valid(lt_d)) begin
          items[nres] = clt_pkg::mk_item(clt_pkg::KindLineErr, '0, '0, clt_pkg::ErrBadType);
          nres = nres + 2'd1;
          disc_d = 1'b1;
        end else begin
          items[nres] = clt_pkg::mk_item(clt_pkg::KindCommand, lt_d, {8'h00, cmd_d}, '0);
          nres = nres + 2'd1;
          if (lt_d == clt_pkg::ChI) begin
            items[nres] = clt_pkg::mk_item(clt_pkg::KindSender, '0, hub_id_i, '0);
            nres = nres + 2'd1;
          end
        end
      end else if (eol) begin
        items[nres] = clt_pkg::mk_item(clt_pkg::KindLineErr, '0, '0, clt_pkg::ErrShort);
        nres = nres + 2'd1;
        disc_d = 1'b1;
      end
      pos_d = pos_d + 4'd1;
    end else if (pos_d == hlen) begin
      pos_d = pos_d + 4'd1;
    end else begin
      if (esc_d) begin
        esc_d = 1'b0;
        if (c == clt_pkg::ChS) begin
          app = 1'b1;
          app_byte = clt_pkg::ChSpace;
        end else if (c == clt_pkg::ChN) begin
          app = 1'b1;
          app_byte = clt_pkg::ChNewline;
        end else if (c == clt_pkg::ChBackslash) begin
          app = 1'b1;
          app_byte = clt_pkg::ChBackslash;
        end else if (c == clt_pkg::ChSpace && legacy_mode_i) begin
          app = 1'b1;
          app_byte = clt_pkg::ChSpace;
        end else begin
          items[nres] = clt_pkg::mk_item(clt_pkg::KindLineErr, '0, '0,
                                         clt_pkg::ErrUnknownEsc);
          nres = nres + 2'd1;
          disc_d = 1'b1;
        end
      end else if (c == clt_pkg::ChBackslash) begin
        esc_d = 1'b1;
        if (eol) begin
          items[nres] = clt_pkg::mk_item(clt_pkg::KindLineErr, '0, '0,
                                         clt_pkg::ErrEscAtEnd);
          nres = nres + 2'd1;
          disc_d = 1'b1;
        end
      end else if (c == clt_pkg::ChSpace) begin
        fin = 1'b1;
      end else begin
        app = 1'b1;
      end
    end

    if (app) begin
      role = clt_pkg::token_role(lt_d, ss_d, ts_d, fs_d);
      case (role)
        clt_pkg::RoleParam: begin
          items[nres] = clt_pkg::mk_item(clt_pkg::KindParamByte, app_byte, '0, '0);
          nres = nres + 2'd1;
        end
        clt_pkg::RoleSender, clt_pkg::RoleTarget: begin
          if (tl_d < 3'd4) idc_d[8*tl_d[1:0] +: 8] = app_byte;
        end
        default: begin
          tm5_d = (tm5_d >= 3'd4) ? 3'd0 : tm5_d + 3'd1;
        end
      endcase
      if (tl_d < 3'd5) tl_d = tl_d + 3'd1;
    end

    if (eol && !disc_d && pos_d >= hlen && tl_d != 3'd0) fin = 1'b1;

    if (fin) begin
      role = clt_pkg::token_role(lt_d, ss_d, ts_d, fs_d);
      case (role)
        clt_pkg::RoleSender, clt_pkg::RoleTarget: begin
          if (tl_d != 3'd4) begin
            items[nres] = clt_pkg::mk_item(clt_pkg::KindLineErr, '0, '0,
                                           clt_pkg::ErrIdLength);
            nres = nres + 2'd1;
            disc_d = 1'b1;
          end else if (role == clt_pkg::RoleSender) begin
            items[nres] = clt_pkg::mk_item(clt_pkg::KindSender, '0, idc_d, '0);
            nres = nres + 2'd1;
            ss_d = 1'b1;
          end else begin
            items[nres] = clt_pkg::mk_item(clt_pkg::KindTarget, '0, idc_d, '0);
            nres = nres + 2'd1;
            ts_d = 1'b1;
          end
        end
        clt_pkg::RoleFeature: begin
          if (tm5_d != 3'd0) begin
            items[nres] = clt_pkg::mk_item(clt_pkg::KindLineErr, '0, '0,
                                           clt_pkg::ErrFeatLength);
            nres = nres + 2'd1;
            disc_d = 1'b1;
          end else begin
            fs_d = 1'b1;
          end
        end
        default: begin
          items[nres] = clt_pkg::mk_item(clt_pkg::KindParamEnd, '0, '0, '0);
          nres = nres + 2'd1;
        end
      endcase
      tl_d  = '0;
      tm5_d = '0;
      idc_d = '0;
    end

    if (eol && !disc_d && pos_d >= hlen) begin
      if (clt_pkg::needs_sender(lt_d) && !ss_d) begin
        items[nres] = clt_pkg::mk_item(clt_pkg::KindLineErr, '0, '0, clt_pkg::ErrNoSender);
      end else if (lt_d == clt_pkg::ChF && !fs_d) begin
        items[nres] = clt_pkg::mk_item(clt_pkg::KindLineErr, '0, '0, clt_pkg::ErrNoFeature);
      end else if (clt_pkg::needs_target(lt_d) && !ts_d) begin
        items[nres] = clt_pkg::mk_item(clt_pkg::KindLineErr, '0, '0, clt_pkg::ErrNoTarget);
      end else begin
        items[nres] = clt_pkg::mk_item(clt_pkg::KindLineOk, '0, '0, '0);
      end
      nres = nres + 2'd1;
    end

    if (eol) begin
      pos_d  = '0;
      lt_d   = '0;
      cmd_d  = '0;
      esc_d  = 1'b0;
      ss_d   = 1'b0;
      ts_d   = 1'b0;
      fs_d   = 1'b0;
      tl_d   = '0;
      tm5_d  = '0;
      idc_d  = '0;
      disc_d = 1'b0;
    end

    if (nres != 2'd0) items[nres - 2'd1].last_of_run = 1'b1;
  end

  assign q_push_o       = accept && (nres != 2'd0);
  assign q_data_o.count = nres;
  assign q_data_o.items = items;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      lt_q   <= '0;
      cmd_q  <= '0;
      esc_q  <= 1'b0;
      ss_q   <= 1'b0;
      ts_q   <= 1'b0;
      fs_q   <= 1'b0;
      tl_q   <= '0;
      tm5_q  <= '0;
      idc_q  <= '0;
      disc_q <= 1'b0;
    end else if (accept) begin
      pos_q  <= pos_d;
      lt_q   <= lt_d;
      cmd_q  <= cmd_d;
      esc_q  <= esc_d;
      ss_q   <= ss_d;
      ts_q   <= ts_d;
      fs_q   <= fs_d;
      tl_q   <= tl_d;
      tm5_q  <= tm5_d;
      idc_q  <= idc_d;
      disc_q <= disc_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/clt_queue.sv @@
`default_nettype none

module clt_queue #(
  parameter int unsigned Depth = clt_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire clt_pkg::bundle_t  data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output clt_pkg::bundle_t       head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  clt_pkg::bundle_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d;
  logic [PtrW-1:0]  rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

@@ hdl/clt_back.sv @@
`default_nettype none

module clt_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_empty_i,
  input  wire clt_pkg::bundle_t    q_head_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output clt_pkg::out_item_t       out_item_o
);

  logic [1:0]         idx_q, idx_d;
  logic               valid_q, valid_d;
  clt_pkg::out_item_t item_q;
  logic               load;
  logic               take;
  logic               last;

  assign load    = ~valid_q | ~out_stall_i;
  assign take    = load & ~q_empty_i;
  assign last    = (idx_q == q_head_i.count - 2'd1);
  assign q_pop_o = take & last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (take) begin
      idx_d   = last ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (load) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= q_head_i.items[idx_q];
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

@@ hdl/command_line_tokenizer_unit.sv @@
// Command line tokenizer: one raw byte per input transfer, line_end on the
// last byte of each line; results come out as typed records (command,
// sender, target, param byte, param end, line ok, line error).
// Input channel: in_valid_i / in_stall_o / in_item_i. Output channel:
// out_valid_o / out_stall_i / out_item_o. last_of_run marks the final
// result caused by one byte. Registers (legacy_mode at 0x0, hub_id at 0x4)
// are written over the APB port; the user must write them only while the
// unit is idle, which the unit itself does not enforce. A byte's first
// result passes through the bundle queue and then the output register;
// further results of the same byte follow one per cycle while the
// receiver does not stall. Bytes are taken one per cycle while they give
// at most one result each and the receiver does not stall; the output
// register delivers one result per cycle while not stalled, and bytes
// giving two or three results are absorbed by the QueueDepth-entry
// bundle queue between the front and back end. Reset clears all line
// state, the queue and the output valid flag; legacy_mode resets to 0
// and hub_id to all ones. When the receiver stalls, the output record
// holds, the queue fills and in_stall_o rises once the queue is full.
`default_nettype none

module command_line_tokenizer_unit #(
  parameter int unsigned QueueDepth = clt_pkg::QueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire clt_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output clt_pkg::out_item_t       out_item_o
);

  logic             legacy_q;
  logic [31:0]      hub_q;
  logic             reg_wr;
  logic             q_full;
  logic             q_push;
  logic             q_empty;
  logic             q_pop;
  clt_pkg::bundle_t q_wdata;
  clt_pkg::bundle_t q_head;

  assign pready = 1'b1;
  assign reg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      legacy_q <= 1'b0;
      hub_q    <= '1;
    end else if (reg_wr) begin
      case (paddr[2])
        clt_pkg::RegLegacyMode: legacy_q <= pwdata[0];
        clt_pkg::RegHubId:      hub_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      clt_pkg::RegLegacyMode: prdata = {31'd0, legacy_q};
      clt_pkg::RegHubId:      prdata = hub_q;
      default:                prdata = '0;
    endcase
  end

  clt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .legacy_mode_i (legacy_q),
    .hub_id_i      (hub_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_item_i     (in_item_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  clt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  clt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
